// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define VPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true
`define VPG_ASSERT_NEVER(label, expr, msg) \
    `VPG_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/vpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Video pixel generator package
// Types, codes and constants shared by the pixel generator modules.
// ----------------------------------------------------------------------------
package vpg_pkg;

    localparam int RUN_MAX   = 8;
    localparam int RUN_IDX_W = $clog2(RUN_MAX);

    localparam logic [7:0] MIXED_SPLIT = 8'(192 - 4 * 8);
    localparam logic [3:0] WHITE_INDEX = 4'hF;
    localparam logic [3:0] BLACK_INDEX = 4'h0;

    localparam logic [2:0] WIDTH_ONE  = 3'd1;
    localparam logic [2:0] WIDTH_TWO  = 3'd2;
    localparam logic [2:0] WIDTH_FOUR = 3'd4;

    // native mode code: {mode[7], mode[1:0]}
    typedef enum logic [2:0] {
        MODE_FOUR_LO = 3'b000,
        MODE_MID_LO  = 3'b001,
        MODE_TEXT32  = 3'b010,
        MODE_HIRES   = 3'b011,
        MODE_FOUR_HI = 3'b100,
        MODE_MID_HI  = 3'b101,
        MODE_TEXT64  = 3'b110,
        MODE_DHIRES  = 3'b111
    } mode_t;

    typedef enum logic [2:0] {
        REG_NATIVE_MODE       = 3'd0,
        REG_COMPAT_SELECT     = 3'd1,
        REG_COMPAT_TEXT       = 3'd2,
        REG_COMPAT_MIXED      = 3'd3,
        REG_PALETTE_SELECT    = 3'd4,
        REG_FOUR_COLOUR_TABLE = 3'd5,
        REG_TWO_COLOUR_TABLE  = 3'd6,
        REG_ARTEFACT_TABLE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  native_mode;
        logic        compat_select;
        logic        compat_text;
        logic        compat_mixed;
        logic [1:0]  palette_select;
        logic [63:0] four_colour_table;
        logic [31:0] two_colour_table;
        logic [15:0] artefact_table;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] attr_byte;
        logic [7:0] glyph_row;
        logic [5:0] column;
        logic [7:0] visible_line;
        logic       blink_phase;
        logic       line_end;
    } item_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][3:0] colour;
        logic [RUN_MAX-1:0][2:0] width;
        logic [RUN_IDX_W-1:0]    last_idx;
    } run_t;

endpackage

// ===== rtl/vpg_if.sv =====
// ----------------------------------------------------------------------------
// Video pixel generator channels
// Valid/ready channels for fetched bytes, pixel runs and register writes.
// ----------------------------------------------------------------------------
interface vpg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] attr_byte;
    logic [7:0] glyph_row;
    logic [5:0] column;
    logic [7:0] visible_line;
    logic       blink_phase;
    logic       line_end;

    modport source (
        output valid, data_byte, attr_byte, glyph_row, column, visible_line,
               blink_phase, line_end,
        input  ready
    );
    modport sink (
        input  valid, data_byte, attr_byte, glyph_row, column, visible_line,
               blink_phase, line_end,
        output ready
    );
endinterface

interface vpg_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] colour_index;
    logic [2:0] repeat_width;
    logic       run_last;

    modport source (output valid, colour_index, repeat_width, run_last, input ready);
    modport sink (input valid, colour_index, repeat_width, run_last, output ready);
endinterface

interface vpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/vpg_decode.sv =====
// ----------------------------------------------------------------------------
// Video pixel generator byte decoder
// Turns one fetched byte into a run of up to eight pixels and keeps the
// artefact-colour pixel delay state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpg_decode
    import vpg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  item_t item,
    input  logic  load,
    output run_t  run_next
);

    logic       prev_lit_reg;
    logic       pend_valid_reg;
    logic [3:0] pend_colour_reg;

    logic       prev_lit_next;
    logic       pend_valid_next;
    logic [3:0] pend_colour_next;

    mode_t      mode;
    logic       text_sel;
    logic       gfx_sel;
    logic       line_start;
    logic       pl0;
    logic       pv0;
    logic [3:0] cl32;
    logic       shown_set;
    logic       inv;
    logic [6:0][3:0] gcol;
    logic [RUN_MAX-1:0][3:0] gseq;

    function automatic logic [3:0] two_colour(input logic [31:0] tbl,
                                              input logic [1:0] pal,
                                              input logic b);
        return tbl[4 * {pal, b} +: 4];
    endfunction

    function automatic logic [3:0] four_colour(input logic [63:0] tbl,
                                               input logic [1:0] pal,
                                               input logic [1:0] c);
        return tbl[4 * {pal, c} +: 4];
    endfunction

    function automatic logic [3:0] artefact_colour(input logic [15:0] tbl,
                                                   input logic odd,
                                                   input logic hi);
        return tbl[4 * {odd, hi} +: 4];
    endfunction

    assign mode       = mode_t'({cfg.native_mode[7], cfg.native_mode[1:0]});
    assign text_sel   = cfg.compat_text ||
                        (cfg.compat_mixed && (item.visible_line >= MIXED_SPLIT));
    assign gfx_sel    = !cfg.compat_select && !text_sel;
    assign line_start = (item.column == '0);
    assign pl0        = prev_lit_reg && !line_start;
    assign pv0        = pend_valid_reg && !line_start;
    assign cl32       = {item.attr_byte[4], item.attr_byte[2:0]};
    assign shown_set  = item.attr_byte[5] || (item.attr_byte[3] && item.blink_phase);
    assign inv        = !item.data_byte[7] && (!item.data_byte[6] || item.blink_phase);

    // artefact colour of each graphics pixel, left to right
    always_comb
    begin
        for (int k = 0; k < 7; k++)
        begin
            if (!item.data_byte[k])
                gcol[k] = BLACK_INDEX;
            else if ((k == 0) ? pl0 : item.data_byte[k-1])
                gcol[k] = WHITE_INDEX;
            else
                gcol[k] = artefact_colour(cfg.artefact_table, item.column[0] ^ 1'(k),
                                          item.data_byte[7]);
        end
        // held pixel turns white when the next pixel is also lit
        gseq[0] = (item.data_byte[0] && pl0) ? WHITE_INDEX : pend_colour_reg;
        for (int k = 1; k < 7; k++)
        begin
            gseq[k] = (item.data_byte[k] && item.data_byte[k-1]) ? WHITE_INDEX
                                                                 : gcol[k-1];
        end
        gseq[7] = gcol[6];
    end

    always_comb
    begin
        run_next.colour   = '0;
        run_next.width    = {RUN_MAX{WIDTH_ONE}};
        run_next.last_idx = RUN_IDX_W'(RUN_MAX - 1);
        prev_lit_next     = 1'b0;
        pend_valid_next   = 1'b0;
        pend_colour_next  = pend_colour_reg;
        if (cfg.compat_select)
        begin
            case (mode)
                MODE_FOUR_LO, MODE_FOUR_HI:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        run_next.colour[k] = four_colour(cfg.four_colour_table,
                                                         cfg.palette_select,
                                                         item.data_byte[2*(3-k) +: 2]);
                        run_next.width[k]  = WIDTH_TWO;
                    end
                    run_next.last_idx = RUN_IDX_W'(3);
                end
                MODE_MID_LO, MODE_MID_HI:
                begin
                    run_next.colour[0] = item.data_byte[7:4];
                    run_next.colour[1] = item.data_byte[3:0];
                    run_next.width[0]  = WIDTH_FOUR;
                    run_next.width[1]  = WIDTH_FOUR;
                    run_next.last_idx  = RUN_IDX_W'(1);
                end
                MODE_TEXT32:
                begin
                    for (int k = 0; k < 7; k++)
                    begin
                        run_next.colour[k] = (item.glyph_row[6-k] ^ !shown_set) ? cl32
                                                                              : BLACK_INDEX;
                        run_next.width[k]  = WIDTH_TWO;
                    end
                    run_next.last_idx = RUN_IDX_W'(6);
                end
                MODE_TEXT64:
                begin
                    for (int k = 0; k < 7; k++)
                    begin
                        run_next.colour[k] = two_colour(cfg.two_colour_table,
                                                        cfg.palette_select,
                                                        item.glyph_row[6-k]);
                    end
                    run_next.last_idx = RUN_IDX_W'(6);
                end
                MODE_HIRES, MODE_DHIRES:
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        run_next.colour[k] = two_colour(cfg.two_colour_table,
                                                        cfg.palette_select,
                                                        item.data_byte[7-k]);
                        run_next.width[k]  = (mode == MODE_HIRES) ? WIDTH_TWO : WIDTH_ONE;
                    end
                    run_next.last_idx = RUN_IDX_W'(7);
                end
                default:
                begin
                    run_next.last_idx = RUN_IDX_W'(7);
                end
            endcase
        end
        else if (text_sel)
        begin
            for (int k = 0; k < 7; k++)
            begin
                run_next.colour[k] = two_colour(cfg.two_colour_table, cfg.palette_select,
                                                item.glyph_row[6-k] ^ inv);
            end
            run_next.last_idx = RUN_IDX_W'(6);
        end
        else
        begin
            // drop the leading slot when nothing is held
            for (int k = 0; k < RUN_MAX - 1; k++)
            begin
                run_next.colour[k] = pv0 ? gseq[k] : gseq[k+1];
            end
            run_next.colour[RUN_MAX-1] = gseq[RUN_MAX-1];
            run_next.last_idx = RUN_IDX_W'(6) - RUN_IDX_W'(!pv0)
                              + RUN_IDX_W'(item.line_end);
            prev_lit_next    = !item.line_end && item.data_byte[6];
            pend_valid_next  = !item.line_end;
            pend_colour_next = gcol[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lit_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_colour_reg <= 4'h0;
        end
        else if (load)
        begin
            prev_lit_reg    <= prev_lit_next;
            pend_valid_reg  <= pend_valid_next;
            pend_colour_reg <= pend_colour_next;
        end
    end

    `VPG_ASSERT(a_other_mode_drops_held, load && !gfx_sel |=> !pend_valid_reg && !prev_lit_reg, "held pixel survived a non-graphics byte")
    `VPG_ASSERT(a_line_end_flushes, load && gfx_sel && item.line_end |=> !pend_valid_reg && !prev_lit_reg, "held pixel survived line end")

endmodule

// ===== rtl/vpg_serializer.sv =====
// ----------------------------------------------------------------------------
// Video pixel generator run serializer
// Holds one decoded run and sends its pixels one per cycle through an
// output register, while pixel.ready does not stall it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpg_serializer
    import vpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  run_t             run_in,
    input  logic             load,
    output logic             load_ready,
    vpg_out_if.source        pixel
);

    run_t                 run_reg;
    logic                 run_valid_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [3:0]           out_colour_reg;
    logic [2:0]           out_width_reg;
    logic                 out_last_reg;

    logic out_load;
    logic at_last;

    assign out_load   = run_valid_reg && (!out_valid_reg || pixel.ready);
    assign at_last    = (idx_reg == run_reg.last_idx);
    assign load_ready = !run_valid_reg || (out_load && at_last);

    assign pixel.valid        = out_valid_reg;
    assign pixel.colour_index = out_colour_reg;
    assign pixel.repeat_width = out_width_reg;
    assign pixel.run_last     = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                run_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (out_load)
            begin
                if (at_last)
                    run_valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pixel.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            run_reg <= run_in;
        if (out_load)
        begin
            out_colour_reg <= run_reg.colour[idx_reg];
            out_width_reg  <= run_reg.width[idx_reg];
            out_last_reg   <= at_last;
        end
    end

    `VPG_ASSERT(a_load_starts_run, load |=> run_valid_reg && (idx_reg == '0), "run not started after load")
    `VPG_ASSERT_NEVER(a_idx_in_run, run_valid_reg && (idx_reg > run_reg.last_idx), "pixel index beyond run")
    `VPG_ASSERT(a_last_marks_end, out_load |=> out_valid_reg && (out_last_reg == $past(at_last)), "run end mark lost")

endmodule

// ===== rtl/video_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// Video pixel generator
// Decodes fetched video bytes into runs of 4-bit colour indices.
// ----------------------------------------------------------------------------
// Channels: fetch takes one video byte with attribute, glyph row, column,
// visible line, blink phase and line end; pixel gives one colour index with
// its repeat width per item, run_last marking the last pixel of a byte; cfg
// writes register index/data and is always ready, to be used while idle.
// Flow: a byte is held in the single run buffer, and each of its pixels then
// passes through the one-pixel output register. Each byte yields 2 to 8
// pixels at one pixel per cycle while pixel.ready is high. The next byte is
// taken in the cycle the last pixel of the current run enters the output
// register.
// Reset: native_mode 2, compat_select 1, all else zero; no pixel pending.
// Stall: while pixel.ready is low the output holds, the run buffer holds,
// and fetch.ready drops once the buffer is full.
// ----------------------------------------------------------------------------
module video_pixel_generator
    import vpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vpg_in_if.sink    fetch,
    vpg_out_if.source pixel,
    vpg_cfg_if.sink   cfg
);

    cfg_t  cfg_reg;
    item_t item;
    run_t  run_next;
    logic  load;
    logic  load_ready;

    assign cfg.ready   = 1'b1;
    assign fetch.ready = load_ready;
    assign load        = fetch.valid && load_ready;

    assign item.data_byte    = fetch.data_byte;
    assign item.attr_byte    = fetch.attr_byte;
    assign item.glyph_row    = fetch.glyph_row;
    assign item.column       = fetch.column;
    assign item.visible_line = fetch.visible_line;
    assign item.blink_phase  = fetch.blink_phase;
    assign item.line_end     = fetch.line_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.native_mode       <= 8'd2;
            cfg_reg.compat_select     <= 1'b1;
            cfg_reg.compat_text       <= 1'b0;
            cfg_reg.compat_mixed      <= 1'b0;
            cfg_reg.palette_select    <= 2'd0;
            cfg_reg.four_colour_table <= '0;
            cfg_reg.two_colour_table  <= '0;
            cfg_reg.artefact_table    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_NATIVE_MODE:       cfg_reg.native_mode       <= cfg.data[7:0];
                REG_COMPAT_SELECT:     cfg_reg.compat_select     <= cfg.data[0];
                REG_COMPAT_TEXT:       cfg_reg.compat_text       <= cfg.data[0];
                REG_COMPAT_MIXED:      cfg_reg.compat_mixed      <= cfg.data[0];
                REG_PALETTE_SELECT:    cfg_reg.palette_select    <= cfg.data[1:0];
                REG_FOUR_COLOUR_TABLE: cfg_reg.four_colour_table <= cfg.data;
                REG_TWO_COLOUR_TABLE:  cfg_reg.two_colour_table  <= cfg.data[31:0];
                REG_ARTEFACT_TABLE:    cfg_reg.artefact_table    <= cfg.data[15:0];
                default:               cfg_reg.native_mode       <= cfg_reg.native_mode;
            endcase
        end
    end

    vpg_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .item     (item),
        .load     (load),
        .run_next (run_next)
    );

    vpg_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_in     (run_next),
        .load       (load),
        .load_ready (load_ready),
        .pixel      (pixel)
    );

endmodule

// ===== sim/pixel_run_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel run checker
// Watches the fetch, pixel and register channels of the pixel generator,
// decodes every accepted byte into its expected pixel run and compares each
// pixel that leaves the block, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
module pixel_run_checker
    import vpg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vpg_in_if    fetch,
    vpg_out_if   pixel,
    vpg_cfg_if   cfg,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] colour;
        logic [2:0] width;
        logic       last;
    } pixel_t;

    cfg_t       regs;
    logic       lit_prev;
    logic       held_valid;
    logic [3:0] held_colour;

    pixel_t     expected_q[$];
    pixel_t     run_buf [RUN_MAX];
    int         run_len;
    item_t      seen;
    int         fail_count = 0;
    int         depth = 0;

    assign errors      = fail_count;
    assign outstanding = depth;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [3:0] two_lookup(input logic b);
        return regs.two_colour_table[4 * (2 * int'(regs.palette_select) + int'(b)) +: 4];
    endfunction

    function automatic logic [3:0] four_lookup(input logic [1:0] c);
        return regs.four_colour_table[4 * (4 * int'(regs.palette_select) + int'(c)) +: 4];
    endfunction

    function automatic void emit(input logic [3:0] colour, input logic [2:0] width);
        run_buf[run_len] = '{colour, width, 1'b0};
        run_len++;
    endfunction

    function automatic void decode_byte(input item_t it);
        int         k;
        logic [3:0] ink;
        logic [3:0] colour;
        logic [1:0] top;
        logic       show_set;
        logic       inv;
        logic       hi;
        logic       odd;

        run_len = 0;
        if (regs.compat_select) begin
            lit_prev   = 1'b0;
            held_valid = 1'b0;
            case (mode_t'({regs.native_mode[7], regs.native_mode[1:0]}))
                MODE_FOUR_LO, MODE_FOUR_HI:
                    for (k = 3; k >= 0; k--)
                        emit(four_lookup(it.data_byte[2 * k +: 2]), WIDTH_TWO);
                MODE_MID_LO, MODE_MID_HI:
                begin
                    emit(it.data_byte[7:4], WIDTH_FOUR);
                    emit(it.data_byte[3:0], WIDTH_FOUR);
                end
                MODE_TEXT32:
                begin
                    ink      = {it.attr_byte[4], it.attr_byte[2:0]};
                    show_set = it.attr_byte[5] | (it.attr_byte[3] & it.blink_phase);
                    for (k = 6; k >= 0; k--)
                        emit((it.glyph_row[k] ^ ~show_set) ? ink : BLACK_INDEX, WIDTH_TWO);
                end
                MODE_TEXT64:
                    for (k = 6; k >= 0; k--)
                        emit(two_lookup(it.glyph_row[k]), WIDTH_ONE);
                MODE_HIRES:
                    for (k = 7; k >= 0; k--)
                        emit(two_lookup(it.data_byte[k]), WIDTH_TWO);
                default:
                    for (k = 7; k >= 0; k--)
                        emit(two_lookup(it.data_byte[k]), WIDTH_ONE);
            endcase
        end
        else if (regs.compat_text || (regs.compat_mixed && it.visible_line >= MIXED_SPLIT)) begin
            top        = it.data_byte[7:6];
            inv        = (top == 2'b00) ? 1'b1 : (top == 2'b01) ? it.blink_phase : 1'b0;
            lit_prev   = 1'b0;
            held_valid = 1'b0;
            for (k = 6; k >= 0; k--)
                emit(two_lookup(it.glyph_row[k] ^ inv), WIDTH_ONE);
        end
        else begin
            hi = it.data_byte[7];
            if (it.column == '0) begin
                held_valid = 1'b0;
                lit_prev   = 1'b0;
            end
            for (k = 0; k < 7; k++) begin
                odd = it.column[0] ^ k[0];
                if (it.data_byte[k]) begin
                    // two neighbouring lit pixels both turn white
                    if (lit_prev) begin
                        colour      = WHITE_INDEX;
                        held_colour = WHITE_INDEX;
                    end
                    else begin
                        colour = regs.artefact_table[4 * (2 * int'(odd) + int'(hi)) +: 4];
                    end
                    lit_prev = 1'b1;
                end
                else begin
                    colour   = BLACK_INDEX;
                    lit_prev = 1'b0;
                end
                if (held_valid)
                    emit(held_colour, WIDTH_ONE);
                held_colour = colour;
                held_valid  = 1'b1;
            end
            if (it.line_end) begin
                emit(held_colour, WIDTH_ONE);
                held_valid = 1'b0;
                lit_prev   = 1'b0;
            end
        end

        if (run_len > 0)
            run_buf[run_len - 1].last = 1'b1;
        for (k = 0; k < run_len; k++)
            expected_q.push_back(run_buf[k]);
    endfunction

    task automatic check_pixel();
        pixel_t want;

        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("pixel colour %0d width %0d last %0d with nothing expected",
                pixel.colour_index, pixel.repeat_width, pixel.run_last));
        end
        else begin
            want = expected_q.pop_front();
            if (pixel.colour_index !== want.colour)
                report_mismatch($sformatf("colour_index %0d, expected %0d",
                    pixel.colour_index, want.colour));
            if (pixel.repeat_width !== want.width)
                report_mismatch($sformatf("repeat_width %0d, expected %0d",
                    pixel.repeat_width, want.width));
            if (pixel.run_last !== want.last)
                report_mismatch($sformatf("run_last %0d, expected %0d",
                    pixel.run_last, want.last));
        end
    endtask

    function automatic void store_reg(input cfg_reg_t idx, input logic [63:0] value);
        case (idx)
            REG_NATIVE_MODE:       regs.native_mode       = value[7:0];
            REG_COMPAT_SELECT:     regs.compat_select     = value[0];
            REG_COMPAT_TEXT:       regs.compat_text       = value[0];
            REG_COMPAT_MIXED:      regs.compat_mixed      = value[0];
            REG_PALETTE_SELECT:    regs.palette_select    = value[1:0];
            REG_FOUR_COLOUR_TABLE: regs.four_colour_table = value;
            REG_TWO_COLOUR_TABLE:  regs.two_colour_table  = value[31:0];
            default:               regs.artefact_table    = value[15:0];
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs               = '0;
            regs.native_mode   = 8'd2;
            regs.compat_select = 1'b1;
            lit_prev           = 1'b0;
            held_valid         = 1'b0;
            held_colour        = '0;
            expected_q.delete();
        end
        else begin
            if (pixel.valid && pixel.ready)
                check_pixel();
            if (cfg.valid && cfg.ready)
                store_reg(cfg_reg_t'(cfg.index), cfg.data);
            if (fetch.valid && fetch.ready) begin
                seen.data_byte    = fetch.data_byte;
                seen.attr_byte    = fetch.attr_byte;
                seen.glyph_row    = fetch.glyph_row;
                seen.column       = fetch.column;
                seen.visible_line = fetch.visible_line;
                seen.blink_phase  = fetch.blink_phase;
                seen.line_end     = fetch.line_end;
                decode_byte(seen);
            end
        end
        depth = expected_q.size();
    end

endmodule

// ===== sim/tb_video_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// Video pixel generator testbench
// Drives fetched bytes through every native and compatible display mode,
// first a directed set of corner cases, then random line sequences under
// random register settings, with bursty fetch traffic and a stalling pixel
// sink. The pixel run checker predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_video_pixel_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import vpg_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 32;

    logic clk;
    logic rst_n;

    vpg_in_if  fetch_if ();
    vpg_out_if pixel_if ();
    vpg_cfg_if cfg_if ();

    int   errors;
    int   outstanding;
    int   burst_left = 0;
    cfg_t setup;

    video_pixel_generator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .fetch (fetch_if),
        .pixel (pixel_if),
        .cfg   (cfg_if)
    );

    pixel_run_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .fetch       (fetch_if),
        .pixel       (pixel_if),
        .cfg         (cfg_if),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input item_t it);
        int gap;

        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge clk);
                fetch_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        fetch_if.valid        <= 1'b1;
        fetch_if.data_byte    <= it.data_byte;
        fetch_if.attr_byte    <= it.attr_byte;
        fetch_if.glyph_row    <= it.glyph_row;
        fetch_if.column       <= it.column;
        fetch_if.visible_line <= it.visible_line;
        fetch_if.blink_phase  <= it.blink_phase;
        fetch_if.line_end     <= it.line_end;
        do @(posedge clk); while (!fetch_if.ready);
        burst_left--;
    endtask

    task automatic send_fields(input logic [7:0] data, input logic [7:0] attr,
                               input logic [7:0] glyph, input logic [5:0] column,
                               input logic [7:0] line, input logic blink,
                               input logic lend);
        item_t it;

        it.data_byte    = data;
        it.attr_byte    = attr;
        it.glyph_row    = glyph;
        it.column       = column;
        it.visible_line = line;
        it.blink_phase  = blink;
        it.line_end     = lend;
        send_item(it);
    endtask

    // hold fetch low and wait for every expected pixel
    task automatic drain();
        @(negedge clk);
        fetch_if.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    task automatic apply_settings(input cfg_t c);
        drain();
        write_reg(REG_NATIVE_MODE,       64'(c.native_mode));
        write_reg(REG_COMPAT_SELECT,     64'(c.compat_select));
        write_reg(REG_COMPAT_TEXT,       64'(c.compat_text));
        write_reg(REG_COMPAT_MIXED,      64'(c.compat_mixed));
        write_reg(REG_PALETTE_SELECT,    64'(c.palette_select));
        write_reg(REG_FOUR_COLOUR_TABLE, c.four_colour_table);
        write_reg(REG_TWO_COLOUR_TABLE,  64'(c.two_colour_table));
        write_reg(REG_ARTEFACT_TABLE,    64'(c.artefact_table));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // pixel sink: alternate open, random, periodic and long-stall stretches
    initial begin
        int kind;
        int len;
        int i;

        pixel_if.ready = 1'b0;
        forever begin
            kind = $urandom_range(0, 3);
            len  = $urandom_range(4, 40);
            for (i = 0; i < len; i++) begin
                @(negedge clk);
                case (kind)
                    0:       pixel_if.ready <= 1'b1;
                    1:       pixel_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       pixel_if.ready <= ((i % 5) < 2);
                    default: pixel_if.ready <= (i >= len - 3);
                endcase
            end
        end
    end

    initial begin
        int idle;

        idle = 0;
        forever begin
            @(posedge clk);
            if ((fetch_if.valid && fetch_if.ready) || (pixel_if.valid && pixel_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int         p;
        int         c;
        int         len;
        int         left;
        item_t      it;
        logic [7:0] row;
        bit         tidy;

        rst_n                 = 1'b0;
        fetch_if.valid        = 1'b0;
        fetch_if.data_byte    = '0;
        fetch_if.attr_byte    = '0;
        fetch_if.glyph_row    = '0;
        fetch_if.column       = '0;
        fetch_if.visible_line = '0;
        fetch_if.blink_phase  = 1'b0;
        fetch_if.line_end     = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_NATIVE_MODE;
        cfg_if.data           = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 32-column text
        send_fields(8'h00, 8'h3F, 8'h55, 6'd0, 8'd0, 1'b0, 1'b0);
        send_fields(8'hFF, 8'h0F, 8'h33, 6'd1, 8'd0, 1'b1, 1'b1);
        send_fields(8'h00, 8'h18, 8'h33, 6'd2, 8'd0, 1'b0, 1'b0);

        setup                   = '0;
        setup.compat_select     = 1'b1;
        setup.palette_select    = 2'd2;
        setup.four_colour_table = 64'hFEDC_BA98_7654_3210;
        setup.two_colour_table  = 32'h1F2E_3D4C;
        setup.artefact_table    = 16'hC9A5;

        setup.native_mode = 8'h00;
        apply_settings(setup);
        send_fields(8'hE4, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0);
        setup.native_mode = 8'h80;
        apply_settings(setup);
        send_fields(8'h1B, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0);
        setup.native_mode = 8'h01;
        apply_settings(setup);
        send_fields(8'hA5, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0);
        setup.native_mode = 8'h81;
        apply_settings(setup);
        send_fields(8'h5A, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0);
        setup.native_mode = 8'h82;
        apply_settings(setup);
        send_fields(8'h00, 8'hFF, 8'h5B, 6'd0, 8'd0, 1'b0, 1'b0);
        setup.native_mode = 8'h03;
        apply_settings(setup);
        send_fields(8'hFF, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0);
        setup.native_mode = 8'h83;
        apply_settings(setup);
        send_fields(8'h96, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0);

        // compatible text: inverse, blinking and normal characters
        setup.compat_select = 1'b0;
        setup.compat_text   = 1'b1;
        apply_settings(setup);
        send_fields(8'h00, 8'h00, 8'h2A, 6'd0, 8'd0, 1'b0, 1'b0);
        send_fields(8'h40, 8'h00, 8'h2A, 6'd1, 8'd0, 1'b1, 1'b0);
        send_fields(8'h40, 8'h00, 8'h2A, 6'd2, 8'd0, 1'b0, 1'b0);
        send_fields(8'hC0, 8'h00, 8'h7F, 6'd3, 8'd0, 1'b0, 1'b1);

        // mixed: graphics above the split line, text from it on
        setup.compat_text  = 1'b0;
        setup.compat_mixed = 1'b1;
        apply_settings(setup);
        send_fields(8'h03, 8'h00, 8'h55, 6'd0, 8'd159, 1'b0, 1'b1);
        send_fields(8'h00, 8'h00, 8'h55, 6'd0, 8'd160, 1'b0, 1'b0);
        send_fields(8'h80, 8'h00, 8'h55, 6'd1, 8'd255, 1'b1, 1'b0);

        // artefact colour: white pairs, flush, high bit, parity, line restart
        setup.compat_mixed = 1'b0;
        apply_settings(setup);
        send_fields(8'h06, 8'h00, 8'h00, 6'd0, 8'd10, 1'b0, 1'b0);
        send_fields(8'hFF, 8'h00, 8'h00, 6'd1, 8'd10, 1'b0, 1'b1);
        send_fields(8'h81, 8'h00, 8'h00, 6'd0, 8'd11, 1'b0, 1'b0);
        send_fields(8'h55, 8'h00, 8'h00, 6'd5, 8'd11, 1'b0, 1'b0);
        send_fields(8'h7F, 8'h00, 8'h00, 6'd0, 8'd12, 1'b0, 1'b0);

        // text drops the held pixel; line end there does nothing
        setup.compat_text = 1'b1;
        apply_settings(setup);
        send_fields(8'hC0, 8'h00, 8'h0F, 6'd1, 8'd12, 1'b0, 1'b1);
        setup.compat_text = 1'b0;
        apply_settings(setup);
        send_fields(8'h01, 8'h00, 8'h00, 6'd7, 8'd12, 1'b0, 1'b1);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            setup.native_mode       = 8'($urandom);
            setup.compat_select     = (p % 3 == 0);
            setup.compat_text       = (p % 3 == 2) ? 1'($urandom) : 1'b0;
            setup.compat_mixed      = 1'($urandom);
            setup.palette_select    = 2'($urandom);
            setup.four_colour_table = {$urandom, $urandom};
            setup.two_colour_table  = $urandom;
            setup.artefact_table    = 16'($urandom);
            if (p == 0) begin
                setup.native_mode       = 8'h00;
                setup.palette_select    = 2'd0;
                setup.four_colour_table = '0;
                setup.two_colour_table  = '0;
                setup.artefact_table    = '0;
            end
            if (p == 1) begin
                setup.palette_select = 2'd0;
                setup.artefact_table = '0;
            end
            if (p == 3) begin
                setup.native_mode       = 8'hFF;
                setup.palette_select    = 2'd3;
                setup.four_colour_table = '1;
                setup.two_colour_table  = '1;
                setup.artefact_table    = '1;
            end
            if (p == 4) begin
                setup.palette_select = 2'd3;
                setup.artefact_table = '1;
            end
            apply_settings(setup);

            // mostly well-formed lines, some with stray columns and line ends
            left = PHASE_ITEMS;
            while (left > 0) begin
                len  = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
                len  = (len > left) ? left : len;
                tidy = ($urandom_range(0, 99) < 85);
                row  = $urandom_range(0, 1) ? 8'($urandom_range(150, 170)) : 8'($urandom);
                for (c = 0; c < len; c++) begin
                    it.data_byte    = 8'($urandom);
                    it.attr_byte    = 8'($urandom);
                    it.glyph_row    = 8'($urandom);
                    it.visible_line = row;
                    it.blink_phase  = 1'($urandom);
                    if (tidy) begin
                        it.column   = 6'(c);
                        it.line_end = (c == len - 1);
                    end
                    else begin
                        it.column   = 6'($urandom);
                        it.line_end = ($urandom_range(0, 3) == 0);
                    end
                    send_item(it);
                end
                left -= len;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
